FILE: rtl/core/tts_pkg.sv
// Package for the timeout timer scheduler: widths, command and event codes, FSM states.
// No dependencies.
package tts_pkg;

  localparam int TIMER_SLOTS_DEF = 16;
  localparam int TIME_W  = 40;
  localparam int DELAY_W = 32;
  localparam int PER_W   = 32;
  localparam int ID_W    = 4;
  localparam int KIND_W  = 3;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_PROC = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    EV_ADDED    = 3'd0,
    EV_FULL     = 3'd1,
    EV_FIRED    = 3'd2,
    EV_RELEASED = 3'd3,
    EV_DELETED  = 3'd4,
    EV_UNKNOWN  = 3'd5,
    EV_DONE     = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEL,
    ST_FIRE,
    ST_REL,
    ST_FIN,
    ST_FINAL
  } state_t;

endpackage

FILE: rtl/core/tts_if.sv
// Valid/ready channel interfaces for the command and event streams.
// Depends on tts_pkg for field widths.
interface tts_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 command;
  logic [tts_pkg::DELAY_W-1:0] delay_ms;
  logic [tts_pkg::PER_W-1:0]  period_ms;
  logic                       release_notice;
  logic [tts_pkg::ID_W-1:0]   timer_id;
  logic [tts_pkg::TIME_W-1:0] now_ms;
  modport source(output valid, command, delay_ms, period_ms, release_notice, timer_id,
                 now_ms, input ready);
  modport sink(input valid, command, delay_ms, period_ms, release_notice, timer_id,
               now_ms, output ready);
endinterface

interface tts_out_if;
  logic                       valid;
  logic                       ready;
  logic [tts_pkg::KIND_W-1:0] event_kind;
  logic [tts_pkg::ID_W-1:0]   event_id;
  logic                       last;
  logic                       next_valid;
  logic [tts_pkg::TIME_W-1:0] ms_to_next;
  modport source(output valid, event_kind, event_id, last, next_valid, ms_to_next,
                 input ready);
  modport sink(input valid, event_kind, event_id, last, next_valid, ms_to_next,
               output ready);
endinterface

FILE: rtl/core/tts_slot_mem.sv
// Slot memory: one write port, one read port, registered read data.
// Holds period and deadline of each timer slot; no dependencies.
module tts_slot_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 72
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/timeout_timer_scheduler.sv
// Timeout timer scheduler, top level. Uses tts_pkg, tts_if and tts_slot_mem.
// Add and delete do one slot-memory scan before the final beat; a released beat may come first.
// Process scans for due timers, rescans after each one it fires and scans once more before
// the final beat, with a released beat per release. Each scan reads one slot a cycle through the single read port.
// One command is in flight at a time; the next is taken while its final beat still waits.
// Reset (synchronous, active low) clears armed and release bits, time and output valid.
module timeout_timer_scheduler #(
  parameter int TIMER_SLOTS = tts_pkg::TIMER_SLOTS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  tts_in_if.sink      in_if,
  tts_out_if.source   out_if
);

  localparam int IW = $clog2(TIMER_SLOTS);
  localparam int CW = $clog2(TIMER_SLOTS + 1);
  localparam int TW = tts_pkg::TIME_W;
  localparam int PW = tts_pkg::PER_W;
  localparam int MW = TW + PW;

  tts_pkg::state_t state_r, state_nxt;
  logic [TIMER_SLOTS-1:0] armed_r, armed_nxt, wrel_r, wrel_nxt, done_r, done_nxt;
  logic [TW-1:0] cur_r, cur_nxt;
  tts_pkg::kind_t fin_kind_r, fin_kind_nxt;
  logic [tts_pkg::ID_W-1:0] fin_id_r, fin_id_nxt;
  logic [IW-1:0] rel_id_r, rel_id_nxt;
  logic rel_fin_r, rel_fin_nxt;

  logic [CW-1:0] scan_cnt_r;
  logic cmp_v_r;
  logic [IW-1:0] cmp_idx_r;
  logic best_found_r;
  logic [TW-1:0] best_dl_r;
  logic [PW-1:0] best_per_r;
  logic [IW-1:0] best_idx_r;

  logic ov_r, olast_r, onv_r;
  tts_pkg::kind_t okind_r;
  logic [tts_pkg::ID_W-1:0] oid_r;
  logic [TW-1:0] oms_r;

  logic push, push_last, push_nv;
  tts_pkg::kind_t push_kind;
  logic [tts_pkg::ID_W-1:0] push_id;
  logic [TW-1:0] push_ms;

  logic we;
  logic [IW-1:0] waddr;
  logic [MW-1:0] wdata, rdata;
  logic [TW-1:0] rd_dl;
  logic scan_start, scan_done, can_push, elig, id_ok, free_ok;
  logic [IW-1:0] free_idx, id_slot;

  tts_slot_mem #(.DEPTH(TIMER_SLOTS), .WIDTH(MW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (scan_cnt_r[IW-1:0]),
    .rdata (rdata)
  );

  assign rd_dl     = rdata[TW-1:0];
  assign can_push  = !ov_r || out_if.ready;
  assign scan_done = (scan_cnt_r == CW'(TIMER_SLOTS)) && !cmp_v_r;
  assign id_ok     = 32'(in_if.timer_id) < 32'(TIMER_SLOTS);
  assign id_slot   = IW'(in_if.timer_id);

  always_comb begin
    elig = armed_r[cmp_idx_r] && (!best_found_r || rd_dl < best_dl_r);
    if (state_r == tts_pkg::ST_SEL) begin
      elig = elig && !done_r[cmp_idx_r] && (rd_dl <= cur_r);
    end
  end

  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!armed_r[i]) begin
        free_ok  = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    armed_nxt    = armed_r;
    wrel_nxt     = wrel_r;
    done_nxt     = done_r;
    cur_nxt      = cur_r;
    fin_kind_nxt = fin_kind_r;
    fin_id_nxt   = fin_id_r;
    rel_id_nxt   = rel_id_r;
    rel_fin_nxt  = rel_fin_r;
    scan_start   = 1'b0;
    we           = 1'b0;
    waddr        = best_idx_r;
    wdata        = {best_per_r, cur_r + TW'(best_per_r)};
    push         = 1'b0;
    push_kind    = tts_pkg::EV_FIRED;
    push_id      = tts_pkg::ID_W'(best_idx_r);
    push_last    = 1'b0;
    push_nv      = 1'b0;
    push_ms      = '0;
    in_if.ready  = 1'b0;
    unique case (state_r)
      tts_pkg::ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          scan_start = 1'b1;
          state_nxt  = tts_pkg::ST_FIN;
          unique case (in_if.command)
            tts_pkg::CMD_ADD: begin
              if (free_ok) begin
                we                  = 1'b1;
                waddr               = free_idx;
                wdata               = {in_if.period_ms, cur_r + TW'(in_if.delay_ms)};
                armed_nxt[free_idx] = 1'b1;
                wrel_nxt[free_idx]  = in_if.release_notice;
                fin_kind_nxt        = tts_pkg::EV_ADDED;
                fin_id_nxt          = tts_pkg::ID_W'(free_idx);
              end else begin
                fin_kind_nxt = tts_pkg::EV_FULL;
                fin_id_nxt   = '0;
              end
            end
            tts_pkg::CMD_DEL: begin
              fin_id_nxt = in_if.timer_id;
              if (id_ok && armed_r[id_slot]) begin
                armed_nxt[id_slot] = 1'b0;
                wrel_nxt[id_slot]  = 1'b0;
                fin_kind_nxt       = tts_pkg::EV_DELETED;
                rel_id_nxt         = id_slot;
                rel_fin_nxt        = 1'b1;
                if (wrel_r[id_slot]) begin
                  state_nxt = tts_pkg::ST_REL;
                end
              end else begin
                fin_kind_nxt = tts_pkg::EV_UNKNOWN;
              end
            end
            tts_pkg::CMD_PROC: begin
              fin_kind_nxt = tts_pkg::EV_DONE;
              fin_id_nxt   = '0;
              if (|armed_r) begin
                cur_nxt   = in_if.now_ms;
                done_nxt  = '0;
                state_nxt = tts_pkg::ST_SEL;
              end
            end
            default: begin
              fin_kind_nxt = tts_pkg::EV_DONE;
              fin_id_nxt   = '0;
            end
          endcase
        end
      end
      tts_pkg::ST_SEL: begin
        if (scan_done) begin
          if (best_found_r) begin
            state_nxt = tts_pkg::ST_FIRE;
          end else begin
            scan_start = 1'b1;
            state_nxt  = tts_pkg::ST_FIN;
          end
        end
      end
      tts_pkg::ST_FIRE: begin
        if (can_push) begin
          push                 = 1'b1;
          done_nxt[best_idx_r] = 1'b1;
          scan_start           = 1'b1;
          state_nxt            = tts_pkg::ST_SEL;
          if (best_per_r != '0) begin
            we = 1'b1;
          end else begin
            armed_nxt[best_idx_r] = 1'b0;
            wrel_nxt[best_idx_r]  = 1'b0;
            if (wrel_r[best_idx_r]) begin
              rel_id_nxt  = best_idx_r;
              rel_fin_nxt = 1'b0;
              state_nxt   = tts_pkg::ST_REL;
            end
          end
        end
      end
      tts_pkg::ST_REL: begin
        if (can_push) begin
          push       = 1'b1;
          push_kind  = tts_pkg::EV_RELEASED;
          push_id    = tts_pkg::ID_W'(rel_id_r);
          scan_start = 1'b1;
          state_nxt  = rel_fin_r ? tts_pkg::ST_FIN : tts_pkg::ST_SEL;
        end
      end
      tts_pkg::ST_FIN: begin
        if (scan_done) begin
          state_nxt = tts_pkg::ST_FINAL;
        end
      end
      tts_pkg::ST_FINAL: begin
        if (can_push) begin
          push      = 1'b1;
          push_kind = fin_kind_r;
          push_id   = fin_id_r;
          push_last = 1'b1;
          push_nv   = best_found_r;
          push_ms   = (best_found_r && best_dl_r > cur_r) ? best_dl_r - cur_r : '0;
          state_nxt = tts_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tts_pkg::ST_IDLE;
      armed_r <= '0;
      wrel_r  <= '0;
      done_r  <= '0;
      cur_r   <= '0;
      ov_r    <= 1'b0;
      cmp_v_r <= 1'b0;
      scan_cnt_r   <= '0;
      best_found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      armed_r <= armed_nxt;
      wrel_r  <= wrel_nxt;
      done_r  <= done_nxt;
      cur_r   <= cur_nxt;
      if (push) begin
        ov_r <= 1'b1;
      end else if (out_if.ready) begin
        ov_r <= 1'b0;
      end
      if (scan_start) begin
        scan_cnt_r   <= '0;
        cmp_v_r      <= 1'b0;
        best_found_r <= 1'b0;
      end else if (state_r == tts_pkg::ST_SEL || state_r == tts_pkg::ST_FIN) begin
        if (scan_cnt_r != CW'(TIMER_SLOTS)) begin
          scan_cnt_r <= scan_cnt_r + CW'(1);
          cmp_v_r    <= 1'b1;
        end else begin
          cmp_v_r <= 1'b0;
        end
        if (cmp_v_r && elig) begin
          best_found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    fin_kind_r <= fin_kind_nxt;
    fin_id_r   <= fin_id_nxt;
    rel_id_r   <= rel_id_nxt;
    rel_fin_r  <= rel_fin_nxt;
    cmp_idx_r  <= scan_cnt_r[IW-1:0];
    if (!scan_start && cmp_v_r && elig &&
        (state_r == tts_pkg::ST_SEL || state_r == tts_pkg::ST_FIN)) begin
      best_dl_r  <= rd_dl;
      best_per_r <= rdata[MW-1:TW];
      best_idx_r <= cmp_idx_r;
    end
    if (push) begin
      okind_r <= push_kind;
      oid_r   <= push_id;
      olast_r <= push_last;
      onv_r   <= push_nv;
      oms_r   <= push_ms;
    end
  end

  assign out_if.valid      = ov_r;
  assign out_if.event_kind = okind_r;
  assign out_if.event_id   = oid_r;
  assign out_if.last       = olast_r;
  assign out_if.next_valid = onv_r;
  assign out_if.ms_to_next = oms_r;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("command accepted while previous command in flight");
  a_ms_needs_next: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && oms_r != '0) |-> onv_r)
    else $error("time to next deadline without an armed timer");
  a_nonfinal_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !olast_r) |-> (!onv_r && oms_r == '0))
    else $error("non-final beat carries next-deadline fields");
  a_final_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_last) |=> (state_r == tts_pkg::ST_IDLE))
    else $error("final beat did not return to idle");
`endif

endmodule
